// ----- rtl/ipfs_pkg.sv -----
// Package for the infrared pulse frame sender.
// Holds frame sizes, request and register codes, and the channel and config structs.
// No dependencies.
package ipfs_pkg;

    localparam int WORD_BITS   = 8;
    localparam int FRAME_LEN   = WORD_BITS + 4;
    localparam int SIDX_W      = $clog2(FRAME_LEN + 1);
    localparam int FIDX_W      = $clog2(FRAME_LEN);
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;

    localparam logic [7:0] IDLE_RELOAD = 8'd210;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    localparam logic [2:0] REG_MARK_RELOAD   = 3'd0;
    localparam logic [2:0] REG_SPACE_RELOAD  = 3'd1;
    localparam logic [2:0] REG_MARK_TOGGLES  = 3'd2;
    localparam logic [2:0] REG_SPACE_TOGGLES = 3'd3;
    localparam logic [2:0] REG_OMNI_MODE     = 3'd4;
    localparam logic [2:0] REG_SENSOR_SELECT = 3'd5;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_word;
    } ipfs_in_t;

    typedef struct packed {
        logic       ir_level;
        logic [7:0] timer_reload;
        logic       frame_done;
        logic       busy_res;
    } ipfs_out_t;

    typedef struct packed {
        logic [7:0] mark_reload;
        logic [7:0] space_reload;
        logic [7:0] mark_toggles;
        logic [7:0] space_toggles;
        logic       omni_mode;
        logic [2:0] sensor_select;
    } ipfs_cfg_t;

endpackage

// ----- rtl/ipfs_regs.sv -----
// Configuration registers of the infrared pulse frame sender, on an APB-style port.
// Depends on ipfs_pkg.
module ipfs_regs
    import ipfs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output ipfs_cfg_t          cfg
);

    ipfs_cfg_t  cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mark_reload   <= 8'd0;
            cfg_reg.space_reload  <= 8'd0;
            cfg_reg.mark_toggles  <= 8'd1;
            cfg_reg.space_toggles <= 8'd1;
            cfg_reg.omni_mode     <= 1'b1;
            cfg_reg.sensor_select <= 3'd0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MARK_RELOAD:   cfg_reg.mark_reload   <= pwdata[7:0];
                REG_SPACE_RELOAD:  cfg_reg.space_reload  <= pwdata[7:0];
                REG_MARK_TOGGLES:  cfg_reg.mark_toggles  <= pwdata[7:0];
                REG_SPACE_TOGGLES: cfg_reg.space_toggles <= pwdata[7:0];
                REG_OMNI_MODE:     cfg_reg.omni_mode     <= pwdata[0];
                REG_SENSOR_SELECT: cfg_reg.sensor_select <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MARK_RELOAD:   prdata = {24'd0, cfg_reg.mark_reload};
            REG_SPACE_RELOAD:  prdata = {24'd0, cfg_reg.space_reload};
            REG_MARK_TOGGLES:  prdata = {24'd0, cfg_reg.mark_toggles};
            REG_SPACE_TOGGLES: prdata = {24'd0, cfg_reg.space_toggles};
            REG_OMNI_MODE:     prdata = {31'd0, cfg_reg.omni_mode};
            REG_SENSOR_SELECT: prdata = {29'd0, cfg_reg.sensor_select};
            default:           prdata = '0;
        endcase
    end

endmodule

// ----- rtl/ipfs_core.sv -----
// Frame state and per-request update of the infrared pulse frame sender.
// Depends on ipfs_pkg; result is combinational from the current state and request.
module ipfs_core
    import ipfs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      req_accept,
    input  ipfs_in_t  req,
    input  ipfs_cfg_t cfg,
    output ipfs_out_t result
);

    logic [FRAME_LEN-1:0] frame_reg, frame_next;
    logic [SIDX_W-1:0]    sidx_reg, sidx_next;
    logic [7:0]           tcount_reg, tcount_next;
    logic [7:0]           tlimit_reg, tlimit_next;
    logic                 cur_sym_reg, cur_sym_next;
    logic                 phase_reg, phase_next;
    logic                 pin_reg, pin_next;
    logic                 sending_reg, sending_next;
    logic                 done_reg, done_next;
    logic [7:0]           reload;

    always_comb begin
        logic [WORD_BITS-1:0] data_w;
        logic [1:0]           spaces;
        logic [1:0]           check;
        logic [7:0]           tcount_inc;
        logic                 drive;
        logic                 sym;

        frame_next   = frame_reg;
        sidx_next    = sidx_reg;
        tcount_next  = tcount_reg;
        tlimit_next  = tlimit_reg;
        cur_sym_next = cur_sym_reg;
        phase_next   = phase_reg;
        pin_next     = pin_reg;
        sending_next = sending_reg;
        done_next    = done_reg;
        reload       = IDLE_RELOAD;

        data_w = WORD_BITS'(req.data_word);
        spaces = 2'd0;
        for (int i = 0; i < WORD_BITS; i++) begin
            spaces = spaces + 2'(data_w[i]);
        end
        check      = 2'd0 - spaces;
        tcount_inc = tcount_reg + 8'd1;
        drive      = cfg.omni_mode || (cfg.sensor_select == 3'd0);
        sym        = 1'b0;

        if (req.req_type == REQ_START) begin
            // first symbol is always a mark
            frame_next   = {check[0], check[1], data_w, 2'b00};
            done_next    = 1'b0;
            phase_next   = 1'b0;
            sending_next = 1'b1;
            tcount_next  = 8'd0;
            tlimit_next  = cfg.mark_toggles;
            cur_sym_next = 1'b0;
            sidx_next    = SIDX_W'(1);
            reload       = cfg.mark_reload;
        end else if (sending_reg) begin
            if (drive) begin
                pin_next = ~phase_reg;
            end
            phase_next  = ~phase_reg;
            tcount_next = tcount_inc;
            if (tcount_inc >= tlimit_reg) begin
                if (sidx_reg < SIDX_W'(FRAME_LEN)) begin
                    sym          = frame_reg[sidx_reg[FIDX_W-1:0]];
                    tcount_next  = 8'd0;
                    tlimit_next  = sym ? cfg.space_toggles : cfg.mark_toggles;
                    cur_sym_next = sym;
                    sidx_next    = sidx_reg + SIDX_W'(1);
                    reload       = sym ? cfg.space_reload : cfg.mark_reload;
                end else begin
                    pin_next     = 1'b0;
                    done_next    = 1'b1;
                    sending_next = 1'b0;
                    reload       = IDLE_RELOAD;
                end
            end else begin
                reload = cur_sym_reg ? cfg.space_reload : cfg.mark_reload;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg   <= '0;
            sidx_reg    <= '0;
            tcount_reg  <= 8'd0;
            tlimit_reg  <= 8'd0;
            cur_sym_reg <= 1'b0;
            phase_reg   <= 1'b0;
            pin_reg     <= 1'b0;
            sending_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else if (req_accept) begin
            frame_reg   <= frame_next;
            sidx_reg    <= sidx_next;
            tcount_reg  <= tcount_next;
            tlimit_reg  <= tlimit_next;
            cur_sym_reg <= cur_sym_next;
            phase_reg   <= phase_next;
            pin_reg     <= pin_next;
            sending_reg <= sending_next;
            done_reg    <= done_next;
        end
    end

    assign result.ir_level     = pin_next;
    assign result.timer_reload = reload;
    assign result.frame_done   = done_next;
    assign result.busy_res     = sending_next;

endmodule

// ----- rtl/ir_pulse_frame_sender.sv -----
// Top level of the infrared pulse frame sender: config registers, frame core, result register.
// Depends on ipfs_pkg, ipfs_regs and ipfs_core.
//
//   channel   ports             payload      direction
//   request   s_valid/s_ready   ipfs_in_t    in
//   result    m_valid/m_ready   ipfs_out_t   out
//   config    psel/penable/...  32-bit regs  in/out (APB-style)
//
// One request per cycle while s_ready is high; its result is in the result register the cycle after.
// The single result register sets the rate: a request is taken whenever that register
// is empty or being emptied in the same cycle.
// Synchronous active-low reset clears frame state and result valid, and loads config defaults.
module ir_pulse_frame_sender
    import ipfs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ipfs_in_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ipfs_out_t          m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    ipfs_cfg_t cfg;
    ipfs_out_t result;
    ipfs_out_t out_reg;
    logic      m_valid_reg;
    logic      accept;

    assign pready  = 1'b1;
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    ipfs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    ipfs_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_accept (accept),
        .req        (s_data),
        .cfg        (cfg),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= result;
        end
    end

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.req_type == REQ_START)
        |=> (m_valid && m_data.busy_res && !m_data.frame_done))
        else $error("start request did not yield a busy result");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.frame_done) |-> (!m_data.busy_res && !m_data.ir_level))
        else $error("done result with busy or pin high");

    a_idle_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.busy_res) |-> (m_data.timer_reload == IDLE_RELOAD))
        else $error("idle result without idle reload");

endmodule

// ----- verif/ipfs_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the infrared pulse frame sender: tracks config writes, predicts each result.
// Depends on ipfs_pkg; sits beside the dut and only watches its ports.
module ipfs_checker
    import ipfs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  ipfs_in_t           s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  ipfs_out_t          m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 outstanding,
    output int                 fail_count,
    output int                 result_count
);

    logic [7:0] cfg_mr, cfg_sr, cfg_mt, cfg_st;
    logic       cfg_omni;
    logic [2:0] cfg_sel;

    logic [FRAME_LEN-1:0] frame_sym;
    logic [SIDX_W-1:0]    sym_idx;
    logic [7:0]           tog_cnt, tog_lim;
    logic                 phase, pin, sending, done_f;

    ipfs_out_t expected_results_q[$];
    ipfs_out_t exp_res, new_res;
    int        fails, seen;

    task automatic load_next_symbol(output logic [7:0] r);
        if (sym_idx < FRAME_LEN) begin
            tog_cnt = 8'd0;
            r       = frame_sym[sym_idx] ? cfg_sr : cfg_mr;
            tog_lim = frame_sym[sym_idx] ? cfg_st : cfg_mt;
            sym_idx = sym_idx + 1'b1;
        end else begin
            pin     = 1'b0;
            done_f  = 1'b1;
            sending = 1'b0;
            r       = IDLE_RELOAD;
        end
    endtask

    task automatic sender_step(input ipfs_in_t req, output ipfs_out_t res);
        logic [7:0] reload;
        logic [1:0] chk;
        logic       drive;
        if (req.req_type == REQ_START) begin
            // check bits: minus the space count, mod 4
            chk       = 2'd0 - 2'($countones(req.data_word));
            frame_sym = {chk[0], chk[1], req.data_word, 2'b00};
            done_f    = 1'b0;
            sym_idx   = '0;
            phase     = 1'b0;
            load_next_symbol(reload);
            sending   = 1'b1;
        end else if (!sending) begin
            reload = IDLE_RELOAD;
        end else begin
            drive = cfg_omni || (cfg_sel == 3'd0);
            if (drive) begin
                pin = ~phase;
            end
            phase   = ~phase;
            tog_cnt = tog_cnt + 8'd1;
            if (tog_cnt >= tog_lim) begin
                load_next_symbol(reload);
            end else begin
                reload = frame_sym[sym_idx - 1'b1] ? cfg_sr : cfg_mr;
            end
        end
        res.ir_level     = pin;
        res.timer_reload = reload;
        res.frame_done   = done_f;
        res.busy_res     = sending;
    endtask

    task automatic flag_field(input string name, input logic [7:0] e, input logic [7:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
            fails++;
        end
    endtask

    initial begin
        fails = 0;
        seen  = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_mr    = 8'd0;
            cfg_sr    = 8'd0;
            cfg_mt    = 8'd1;
            cfg_st    = 8'd1;
            cfg_omni  = 1'b1;
            cfg_sel   = 3'd0;
            frame_sym = '0;
            sym_idx   = '0;
            tog_cnt   = 8'd0;
            tog_lim   = 8'd0;
            phase     = 1'b0;
            pin       = 1'b0;
            sending   = 1'b0;
            done_f    = 1'b0;
            expected_results_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_MARK_RELOAD:   cfg_mr   = pwdata[7:0];
                    REG_SPACE_RELOAD:  cfg_sr   = pwdata[7:0];
                    REG_MARK_TOGGLES:  cfg_mt   = pwdata[7:0];
                    REG_SPACE_TOGGLES: cfg_st   = pwdata[7:0];
                    REG_OMNI_MODE:     cfg_omni = pwdata[0];
                    REG_SENSOR_SELECT: cfg_sel  = pwdata[2:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                sender_step(s_data, new_res);
                expected_results_q.push_back(new_res);
            end
            if (m_valid && m_ready) begin
                seen++;
                if (expected_results_q.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, got %p",
                             $time, m_data);
                    fails++;
                end else begin
                    exp_res = expected_results_q.pop_front();
                    flag_field("ir_level", exp_res.ir_level, m_data.ir_level);
                    flag_field("timer_reload", exp_res.timer_reload, m_data.timer_reload);
                    flag_field("frame_done", exp_res.frame_done, m_data.frame_done);
                    flag_field("busy_res", exp_res.busy_res, m_data.busy_res);
                end
            end
        end
        outstanding  <= expected_results_q.size();
        fail_count   <= fails;
        result_count <= seen;
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Top of the infrared pulse frame sender testbench: clock, reset, request and config stimulus.
// Depends on ipfs_pkg, ir_pulse_frame_sender and ipfs_checker.
module tb
    import ipfs_pkg::*;
();

    localparam int LIMIT      = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 1500;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    ipfs_in_t           s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    ipfs_out_t          m_data;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int outstanding, fail_count, result_count;
    int cycles = 0;
    int n_sent = 0, n_starts = 0, n_ticks = 0, n_settings = 0;
    bit tx_idle_on = 1'b0, rx_idle_on = 1'b0, hold_req = 1'b0;

    logic [7:0] cfg_mr, cfg_sr, cfg_mt, cfg_st;
    logic       cfg_omni;
    logic [2:0] cfg_sel;

    ir_pulse_frame_sender dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    ipfs_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .outstanding(outstanding), .fail_count(fail_count), .result_count(result_count)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: per-result stall, plus one long hold-off on request
    initial begin
        int w;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (m_valid && m_ready) begin
                w = rx_idle_on ? $urandom_range(0, 17) : 0;
                if (w > 0) begin
                    m_ready <= 1'b0;
                    repeat (w) @(posedge aclk);
                    m_ready <= 1'b1;
                end
            end else if (!m_ready) begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_req(input logic t, input logic [7:0] d);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_data.req_type  <= t;
        s_data.data_word <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
        if (t == REQ_START) n_starts++;
        else n_ticks++;
    endtask

    task automatic send_ticks(input int n);
        for (int i = 0; i < n; i++) send_req(REQ_TICK, 8'($urandom));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [7:0] mr, input logic [7:0] sr, input logic [7:0] mt,
                              input logic [7:0] st, input logic om, input logic [2:0] sel);
        drain();
        cfg_mr = mr; cfg_sr = sr; cfg_mt = mt; cfg_st = st; cfg_omni = om; cfg_sel = sel;
        apb_write(REG_MARK_RELOAD, mr);
        apb_write(REG_SPACE_RELOAD, sr);
        apb_write(REG_MARK_TOGGLES, mt);
        apb_write(REG_SPACE_TOGGLES, st);
        apb_write(REG_OMNI_MODE, {7'($urandom), om});
        apb_write(REG_SENSOR_SELECT, {5'($urandom), sel});
        @(posedge aclk);
        n_settings++;
    endtask

    // ticks that one frame of this word takes under the current setting
    function automatic int frame_ticks(input logic [7:0] d);
        logic [1:0]           c;
        logic [FRAME_LEN-1:0] f;
        int                   n;
        c = 2'd0 - 2'($countones(d));
        f = {c[0], c[1], d, 2'b00};
        n = 0;
        for (int i = 0; i < FRAME_LEN; i++) begin
            if (f[i]) n += (cfg_st == 0) ? 1 : cfg_st;
            else n += (cfg_mt == 0) ? 1 : cfg_mt;
        end
        return n;
    endfunction

    task automatic run_phase(input int budget, input bit one_frame);
        int         first, kind, n;
        logic [7:0] d;
        first = n_sent;
        if (one_frame) begin
            d = 8'($urandom);
            send_req(REQ_START, d);
            send_ticks(frame_ticks(d) + 1);
        end
        while (!one_frame && n_sent - first < budget) begin
            kind = $urandom_range(0, 9);
            d    = 8'($urandom);
            if (kind <= 6) begin
                send_req(REQ_START, d);
                send_ticks(frame_ticks(d) + $urandom_range(0, 2));
            end else if (kind == 7) begin
                send_req(REQ_START, d);
                send_ticks($urandom_range(0, frame_ticks(d) - 1));
            end else if (kind == 8) begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++) send_req(1'($urandom), 8'($urandom));
            end else begin
                send_req(REQ_START, d);
                send_req(REQ_START, 8'($urandom));
            end
        end
    endtask

    initial begin
        int directed_n;
        cfg_mr = 8'd0; cfg_sr = 8'd0; cfg_mt = 8'd1; cfg_st = 8'd1;
        cfg_omni = 1'b1; cfg_sel = 3'd0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset setting: idle tick, abandoned frame, restart, full frame, idle tick, second full frame, idle tick
        send_req(REQ_TICK, 8'h00);
        send_req(REQ_START, 8'hff);
        send_ticks(3);
        send_req(REQ_START, 8'h00);
        send_ticks(FRAME_LEN);
        send_req(REQ_TICK, 8'hff);
        send_req(REQ_START, 8'h01);
        send_ticks(FRAME_LEN + 1);
        directed_n = n_sent;

        tx_idle_on = 1'b1; rx_idle_on = 1'b1;
        set_config(8'd0, 8'd255, 8'd0, 8'd0, 1'b0, 3'd0);
        run_phase(150, 1'b0);
        tx_idle_on = 1'b1; rx_idle_on = 1'b0;
        set_config(8'd255, 8'd0, 8'd1, 8'd2, 1'b0, 3'd7);
        hold_req = 1'b1;
        run_phase(150, 1'b0);
        tx_idle_on = 1'b0; rx_idle_on = 1'b1;
        set_config(8'($urandom), 8'($urandom), 8'd3, 8'd1, 1'b1, 3'd5);
        run_phase(150, 1'b0);
        tx_idle_on = 1'b0; rx_idle_on = 1'b0;
        set_config(8'd170, 8'd85, 8'd40, 8'd0, 1'b1, 3'd3);
        run_phase(0, 1'b1);
        set_config(8'd85, 8'd170, 8'd0, 8'd40, 1'b0, 3'd0);
        run_phase(0, 1'b1);

        while (n_sent < directed_n + RANDOM_ITEMS) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            set_config(8'($urandom), 8'($urandom),
                       8'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 12)
                                                      : $urandom_range(0, 4)),
                       8'($urandom_range(0, 4)), 1'($urandom), 3'($urandom));
            run_phase(150, 1'b0);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("run covered %0d requests (%0d starts, %0d ticks), %0d results checked,",
                 n_sent, n_starts, n_ticks, result_count);
        $display("across %0d register settings with one long result stall", n_settings);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
